FILE: rtl/histogram_zone_ratio_macros.svh
// ---------------------------------------------------------------------------
// histogram_zone_ratio assertion macros
// shared property wrappers for the histogram zone ratio block
// ---------------------------------------------------------------------------
`ifndef HISTOGRAM_ZONE_RATIO_MACROS_SVH
`define HISTOGRAM_ZONE_RATIO_MACROS_SVH

`ifndef SYNTH

`define HZR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hzr assertion failed");

`define HZR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hzr assertion failed");

`else

`define HZR_ASSERT_IMP(label, clk, rst, ante, cons)

`define HZR_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/hzr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hzr_pkg
// widths, constants and controller/datapath interface types
// ---------------------------------------------------------------------------
package hzr_pkg;

   localparam int TIME_W  = 24;
   localparam int COUNT_W = 16;
   localparam int ZONE_W  = 23;
   localparam int ACC_W   = 28;
   localparam int RATIO_W = 17;
   localparam int FRAC_W  = 16;

   localparam int REG_IDX_W = 1;
   localparam logic [REG_IDX_W-1:0] REG_WIDE_ZONE   = 1'd0;
   localparam logic [REG_IDX_W-1:0] REG_NARROW_ZONE = 1'd1;

   localparam logic [ZONE_W-1:0]  WIDE_ZONE_RESET   = 23'd15000;
   localparam logic [ZONE_W-1:0]  NARROW_ZONE_RESET = 23'd2000;
   localparam logic [RATIO_W-1:0] RATIO_ONE         = 17'h10000;

   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int DIV_STEPS  = FRAC_W;
   localparam int STEP_CNT_W = $clog2(DIV_STEPS);

   localparam int IN_DATA_W  = ((TIME_W + COUNT_W + 7) / 8) * 8;
   localparam int OUT_USED_W = 5 * ACC_W + RATIO_W;
   localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

   typedef struct packed {
      logic acc_en;
      logic prep;
      logic check;
      logic div_step;
   } hzr_cmd_type;

   typedef struct packed {
      logic wide_zero;
      logic narrow_ge;
   } hzr_status_type;

endpackage

FILE: rtl/hzr_ctrl.sv
`timescale 1ns / 1ps
`include "histogram_zone_ratio_macros.svh"
// ---------------------------------------------------------------------------
// hzr_ctrl
// sequencer: bin accumulation, ratio divide steps and result handshake
// ---------------------------------------------------------------------------
module hzr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  hzr_pkg::hzr_status_type status,
   output hzr_pkg::hzr_cmd_type    cmd
);
   import hzr_pkg::*;

   typedef enum logic [2:0] {
      ST_ACC,
      ST_PREP,
      ST_CHECK,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [STEP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    accept;

   assign req_tready = (state_ff == ST_ACC) || ((state_ff == ST_DONE) && rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   assign cmd.acc_en   = accept;
   assign cmd.prep     = (state_ff == ST_PREP);
   assign cmd.check    = (state_ff == ST_CHECK);
   assign cmd.div_step = (state_ff == ST_DIV);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_ACC: begin
            if (accept && req_tlast) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cnt_in = STEP_CNT_W'(DIV_STEPS - 1);
            if (status.wide_zero || status.narrow_ge) begin
               state_in     = ST_DONE;
               rsp_valid_in = 1'b1;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in     = ST_DONE;
               rsp_valid_in = 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = (accept && req_tlast) ? ST_PREP : ST_ACC;
            end
         end
         default: begin
            state_in     = ST_ACC;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `HZR_ASSERT_NXT(a_last_starts_prep, clock, reset, accept && req_tlast, state_ff == ST_PREP)
   `HZR_ASSERT_NXT(a_div_ends_done, clock, reset, (state_ff == ST_DIV) && (cnt_ff == '0), rsp_tvalid)
   `HZR_ASSERT_IMP(a_busy_no_ready, clock, reset, (state_ff != ST_ACC) && (state_ff != ST_DONE), !req_tready)

endmodule

FILE: rtl/hzr_dp.sv
`timescale 1ns / 1ps
`include "histogram_zone_ratio_macros.svh"
// ---------------------------------------------------------------------------
// hzr_dp
// zone registers, saturating accumulators, result snapshot and divider
// ---------------------------------------------------------------------------
module hzr_dp #(
   parameter int COUNT_BITS = hzr_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  hzr_pkg::hzr_cmd_type           cmd,
   input  logic                           csr_we,
   input  logic [hzr_pkg::REG_IDX_W-1:0]  csr_addr,
   input  logic [hzr_pkg::ZONE_W-1:0]     csr_wdata,
   input  logic signed [hzr_pkg::TIME_W-1:0] bin_time,
   input  logic [hzr_pkg::COUNT_W-1:0]    bin_count,
   input  logic                           is_last,
   output logic [hzr_pkg::ACC_W-1:0]      neg_wide_sum,
   output logic [hzr_pkg::ACC_W-1:0]      pos_wide_sum,
   output logic [hzr_pkg::ACC_W-1:0]      neg_narrow_sum,
   output logic [hzr_pkg::ACC_W-1:0]      pos_narrow_sum,
   output logic [hzr_pkg::ACC_W-1:0]      total_sum,
   output logic [hzr_pkg::RATIO_W-1:0]    narrow_ratio,
   output logic                           no_wide_events,
   output hzr_pkg::hzr_status_type        status
);
   import hzr_pkg::*;

   localparam logic [COUNT_W-1:0] CountMask =
      (COUNT_BITS >= COUNT_W) ? {COUNT_W{1'b1}} : COUNT_W'((1 << COUNT_BITS) - 1);
   localparam int SumW = ACC_W + 1;
   localparam int RemW = ACC_W + 2;
   localparam int LimW = ZONE_W + 2;

   logic [ZONE_W-1:0]  wide_zone_ff, narrow_zone_ff;
   logic [ACC_W-1:0]   acc_nw_ff, acc_pw_ff, acc_nn_ff, acc_pn_ff, acc_tot_ff;
   logic [ACC_W-1:0]   acc_nw_in, acc_pw_in, acc_nn_in, acc_pn_in, acc_tot_in;
   logic [ACC_W-1:0]   snap_nw_ff, snap_pw_ff, snap_nn_ff, snap_pn_ff, snap_tot_ff;
   logic [SumW-1:0]    wide_ff;
   logic [RemW-1:0]    rem_ff, rem_in;
   logic [RATIO_W-1:0] quo_ff, quo_in;
   logic               none_ff;

   logic [COUNT_W-1:0]      cnt;
   logic signed [LimW-1:0]  t_ext, wide_lim, narrow_lim;
   logic                    t_nonpos, t_nonneg;
   logic                    hit_nw, hit_pw, hit_nn, hit_pn;
   logic [RemW-1:0]         rem_sh, rem_sub;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                input logic [COUNT_W-1:0] val,
                                                input logic en);
      logic [SumW-1:0] s;
      s = {1'b0, acc} + SumW'(val);
      if (!en) begin
         return acc;
      end
      return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
   endfunction

   assign cnt        = bin_count & CountMask;
   assign t_ext      = LimW'(bin_time);
   assign wide_lim   = $signed({2'b00, wide_zone_ff});
   assign narrow_lim = $signed({2'b00, narrow_zone_ff});
   assign t_nonpos   = bin_time[TIME_W-1] || (bin_time == '0);
   assign t_nonneg   = !bin_time[TIME_W-1];

   assign hit_nw = t_nonpos && (t_ext >= -wide_lim);
   assign hit_pw = t_nonneg && (t_ext <= wide_lim);
   assign hit_nn = t_nonpos && (t_ext >= -narrow_lim);
   assign hit_pn = t_nonneg && (t_ext <= narrow_lim);

   assign acc_tot_in = sat_add(acc_tot_ff, cnt, 1'b1);
   assign acc_nw_in  = sat_add(acc_nw_ff, cnt, hit_nw);
   assign acc_pw_in  = sat_add(acc_pw_ff, cnt, hit_pw);
   assign acc_nn_in  = sat_add(acc_nn_ff, cnt, hit_nn);
   assign acc_pn_in  = sat_add(acc_pn_ff, cnt, hit_pn);

   // restoring divide, one quotient bit per step
   assign rem_sh  = {rem_ff[RemW-2:0], 1'b0};
   assign rem_sub = rem_sh - RemW'(wide_ff);

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (rem_sh >= RemW'(wide_ff)) begin
         rem_in = rem_sub;
         quo_in = {quo_ff[RATIO_W-2:0], 1'b1};
      end else begin
         rem_in = rem_sh;
         quo_in = {quo_ff[RATIO_W-2:0], 1'b0};
      end
   end

   assign status.wide_zero = (wide_ff == '0);
   assign status.narrow_ge = (rem_ff >= RemW'(wide_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_zone_ff   <= WIDE_ZONE_RESET;
         narrow_zone_ff <= NARROW_ZONE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_WIDE_ZONE:   wide_zone_ff   <= csr_wdata;
            REG_NARROW_ZONE: narrow_zone_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_nw_ff  <= '0;
         acc_pw_ff  <= '0;
         acc_nn_ff  <= '0;
         acc_pn_ff  <= '0;
         acc_tot_ff <= '0;
      end else if (cmd.acc_en) begin
         if (is_last) begin
            acc_nw_ff  <= '0;
            acc_pw_ff  <= '0;
            acc_nn_ff  <= '0;
            acc_pn_ff  <= '0;
            acc_tot_ff <= '0;
         end else begin
            acc_nw_ff  <= acc_nw_in;
            acc_pw_ff  <= acc_pw_in;
            acc_nn_ff  <= acc_nn_in;
            acc_pn_ff  <= acc_pn_in;
            acc_tot_ff <= acc_tot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_en && is_last) begin
         snap_nw_ff  <= acc_nw_in;
         snap_pw_ff  <= acc_pw_in;
         snap_nn_ff  <= acc_nn_in;
         snap_pn_ff  <= acc_pn_in;
         snap_tot_ff <= acc_tot_in;
      end
      if (cmd.prep) begin
         wide_ff <= {1'b0, snap_nw_ff} + SumW'(snap_pw_ff);
         rem_ff  <= RemW'({1'b0, snap_nn_ff} + SumW'(snap_pn_ff));
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quo_ff  <= '0;
         none_ff <= 1'b0;
      end else if (cmd.check) begin
         none_ff <= status.wide_zero;
         quo_ff  <= (!status.wide_zero && status.narrow_ge) ? RATIO_ONE : '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
      end
   end

   assign neg_wide_sum   = snap_nw_ff;
   assign pos_wide_sum   = snap_pw_ff;
   assign neg_narrow_sum = snap_nn_ff;
   assign pos_narrow_sum = snap_pn_ff;
   assign total_sum      = snap_tot_ff;
   assign narrow_ratio   = quo_ff;
   assign no_wide_events = none_ff;

   `HZR_ASSERT_IMP(a_nw_le_total, clock, reset, 1'b1, acc_nw_ff <= acc_tot_ff)
   `HZR_ASSERT_IMP(a_pn_le_total, clock, reset, 1'b1, acc_pn_ff <= acc_tot_ff)
   `HZR_ASSERT_IMP(a_ratio_sat, clock, reset, 1'b1, quo_ff <= RATIO_ONE)

endmodule

FILE: rtl/histogram_zone_ratio.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// histogram_zone_ratio
// zone sums and narrow/wide ratio over a streamed histogram
// ---------------------------------------------------------------------------
// One bin is taken per clock while a histogram streams in. After the bin
// marked last, input stalls while the ratio is formed: the zone halves are
// added, a check looks for an empty wide zone or a saturating ratio, then
// the restoring divider forms the 16 fraction bits of the quotient, one bit
// per step, unless that check finishes early. The result then waits in the
// output register; the next histogram may start in the cycle the result is
// taken. The user must write the zone registers only while no bin is
// pending; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module histogram_zone_ratio #(
   parameter int COUNT_BITS = hzr_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hzr_pkg::IN_DATA_W-1:0]     req_tdata,  // bin_time, bin_count
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // neg_wide_sum, pos_wide_sum, neg_narrow_sum, pos_narrow_sum, total_sum,
   // narrow_ratio, zero pad
   output logic [hzr_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser,  // no_wide_events
   input  logic                              csr_we,
   input  logic [hzr_pkg::REG_IDX_W-1:0]     csr_addr,
   input  logic [hzr_pkg::ZONE_W-1:0]        csr_wdata
);
   import hzr_pkg::*;

   localparam int OutPadW = OUT_DATA_W - OUT_USED_W;

   hzr_cmd_type    cmd;
   hzr_status_type status;

   logic signed [TIME_W-1:0] bin_time;
   logic [COUNT_W-1:0]       bin_count;
   logic [ACC_W-1:0]         neg_wide_sum, pos_wide_sum, neg_narrow_sum;
   logic [ACC_W-1:0]         pos_narrow_sum, total_sum;
   logic [RATIO_W-1:0]       narrow_ratio;

   assign bin_time  = $signed(req_tdata[TIME_W-1:0]);
   assign bin_count = req_tdata[TIME_W+COUNT_W-1:TIME_W];

   hzr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hzr_dp #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .bin_time       (bin_time),
      .bin_count      (bin_count),
      .is_last        (req_tlast),
      .neg_wide_sum   (neg_wide_sum),
      .pos_wide_sum   (pos_wide_sum),
      .neg_narrow_sum (neg_narrow_sum),
      .pos_narrow_sum (pos_narrow_sum),
      .total_sum      (total_sum),
      .narrow_ratio   (narrow_ratio),
      .no_wide_events (rsp_tuser),
      .status         (status)
   );

   assign rsp_tdata = {{OutPadW{1'b0}}, narrow_ratio, total_sum, pos_narrow_sum,
                       neg_narrow_sum, pos_wide_sum, neg_wide_sum};

endmodule
